### src/fcfl_pkg.sv
// Shared types and constants for the fixed-chunk free-list pool.
`timescale 1ns / 1ps
package fcfl_pkg;

    localparam int NUM_CHUNKS = 256;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int SIZE_W     = 16;
    localparam int COUNT_W    = 9;
    localparam int OFFSET_W   = 24;
    localparam int ADDR_W     = 3;

    localparam logic [COUNT_W-1:0] POOL_CAP = COUNT_W'(NUM_CHUNKS);

    // register indexes
    localparam logic REG_CHUNK_SIZE = 1'b0;
    localparam logic REG_CHUNKS_USE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SIZE_W-1:0] request_bytes;
        logic [7:0]        chunk_to_free;
    } req_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [7:0]          chunk_index;
        logic [OFFSET_W-1:0] byte_offset;
    } res_t;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       push;
        logic       pop;
        logic       fresh;
        logic       load_head;
        logic [1:0] code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic too_large;
        logic list_empty;
        logic fresh_ok;
    } sts_t;

endpackage

### src/fixed_chunk_free_list_pool.sv
// Fixed-size chunk pool with a LIFO free list: result of each request appears in the
// cycle after it is taken (done strobe, one cycle, cannot be held off). A free, a
// failed allocate, or an allocate served from never-used chunks does not raise busy,
// so these can arrive back to back; an allocate that pops the freed list holds busy
// in state S_POP while the next link is read from the synchronous link memory, and
// no request is taken meanwhile. Registers: chunk size at 0x0, chunks in use at
// 0x4. Double frees are not detected.
`timescale 1ns / 1ps
module fixed_chunk_free_list_pool
    import fcfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  req_t              request,
    output logic              done,
    output res_t              result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [SIZE_W-1:0]  chunk_size_reg, chunk_size_next;
    logic [COUNT_W-1:0] chunks_use_reg, chunks_use_next;
    logic               wr_en;
    logic               reg_sel;
    cmd_t               cmd;
    sts_t               sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_comb
    begin
        chunk_size_next = chunk_size_reg;
        chunks_use_next = chunks_use_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_CHUNK_SIZE: chunk_size_next = pwdata[SIZE_W-1:0];
                REG_CHUNKS_USE: chunks_use_next = pwdata[COUNT_W-1:0];
                default:        chunk_size_next = chunk_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg <= SIZE_W'(64);
            chunks_use_reg <= POOL_CAP;
        end
        else
        begin
            chunk_size_reg <= chunk_size_next;
            chunks_use_reg <= chunks_use_next;
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_CHUNK_SIZE: prdata = 32'(chunk_size_reg);
            REG_CHUNKS_USE: prdata = 32'(chunks_use_reg);
            default:        prdata = '0;
        endcase
    end

    fcfl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (request.func),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    fcfl_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .chunk_size    (chunk_size_reg),
        .chunks_in_use (chunks_use_reg),
        .cmd           (cmd),
        .sts           (sts),
        .result        (result)
    );

endmodule

### src/fcfl_ctrl.sv
// Controller: accepts requests, picks the operation, sequences the link read.
`timescale 1ns / 1ps
module fcfl_ctrl
    import fcfl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic func,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic {S_IDLE, S_POP} state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;
    logic   accept;

    assign busy   = (state_reg == S_POP);
    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.load_head = (state_reg == S_POP);
        cmd.code      = ST_OK;
        if (func == FUNC_FREE)
        begin
            cmd.push = accept;
        end
        else if (sts.too_large)
        begin
            cmd.code = ST_TOO_LARGE;
        end
        else if (!sts.list_empty)
        begin
            cmd.pop = accept;
        end
        else if (sts.fresh_ok)
        begin
            cmd.fresh = accept;
        end
        else
        begin
            cmd.code = ST_EMPTY;
        end
    end

    always_comb
    begin
        done_next  = accept;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (cmd.pop) state_next = S_POP;
            S_POP:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result after accepted word");

    a_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> busy && !accept)
        else $error("pop did not block next word");

    a_pop_one: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("link reload took more than one cycle");

endmodule

### src/fcfl_dp.sv
// Datapath: link memory, list head, fresh counter and offset multiplier.
`timescale 1ns / 1ps
module fcfl_dp
    import fcfl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  req_t               request,
    input  logic [SIZE_W-1:0]  chunk_size,
    input  logic [COUNT_W-1:0] chunks_in_use,
    input  cmd_t               cmd,
    output sts_t               sts,
    output res_t               result
);

    // each entry: end mark above the next-chunk link
    logic [IDX_W:0]       link_mem [NUM_CHUNKS];
    logic [IDX_W:0]       rd_reg;

    logic [IDX_W-1:0]     head_reg, head_next;
    logic                 empty_reg, empty_next;
    logic [COUNT_W-1:0]   fresh_reg, fresh_next;
    logic [COUNT_W-1:0]   limit;
    logic [IDX_W-1:0]     free_idx;
    logic [7:0]           idx_sel;
    logic [OFFSET_W-1:0]  product;
    res_t                 result_reg, result_next;

    assign free_idx = IDX_W'(request.chunk_to_free);
    assign limit    = (chunks_in_use > POOL_CAP) ? POOL_CAP : chunks_in_use;

    assign sts.too_large  = request.request_bytes > chunk_size;
    assign sts.list_empty = empty_reg;
    assign sts.fresh_ok   = fresh_reg < limit;

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[free_idx] <= {empty_reg, head_reg};
        end
        rd_reg <= link_mem[head_reg];
    end

    always_comb
    begin
        head_next  = head_reg;
        empty_next = empty_reg;
        fresh_next = fresh_reg;
        if (cmd.push)
        begin
            head_next  = free_idx;
            empty_next = 1'b0;
        end
        else if (cmd.fresh)
        begin
            fresh_next = fresh_reg + COUNT_W'(1);
        end
        else if (cmd.load_head)
        begin
            head_next  = rd_reg[IDX_W-1:0];
            empty_next = rd_reg[IDX_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            empty_reg <= 1'b1;
            fresh_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            empty_reg <= empty_next;
            fresh_reg <= fresh_next;
        end
    end

    always_comb
    begin
        if (cmd.pop)
            idx_sel = 8'(head_reg);
        else if (cmd.fresh)
            idx_sel = fresh_reg[7:0];
        else
            idx_sel = '0;
        product = OFFSET_W'(idx_sel) * OFFSET_W'(chunk_size);

        result_next             = result_reg;
        if (cmd.accept)
        begin
            result_next.status      = cmd.code;
            result_next.chunk_index = idx_sel;
            result_next.byte_offset = product;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
